@@ rtl/i2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_pkg: shared types and constants of the scaled integer to binary64 unit
// Status codes, binary64 field constants, the stage enable group and the
// result group of the normalizer.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int unsigned MAG_W     = 64;
  localparam int unsigned EXP_W     = 16;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned BIASED_W  = 17;
  localparam int unsigned FRAC_BITS = 52;
  localparam int unsigned EXPF_W    = 11;
  localparam int unsigned EXP_BIAS  = 1023;
  localparam int unsigned EXP_MAX   = 2047;

  localparam logic [63:0] NAN_PATTERN = 64'h7FF0_0000_0000_0001;

  typedef enum logic [2:0] {
    ST_NORMAL    = 3'd0,
    ST_ZERO      = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_NAN       = 3'd4
  } i2d_status_e;

  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
  } i2d_stage_en_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_c;
    logic [MAG_W-1:0] norm_d;
  } i2d_norm_t;

  // Index of the highest set bit of a byte, zero for an empty byte.
  function automatic logic [2:0] lead8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/i2d_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_norm: three stage leading one search and normalizing shift
// Stage B finds the leading one inside each byte, stage C picks the top byte
// and shifts by whole bytes, stage D finishes the shift so bit 63 is set.
// ----------------------------------------------------------------------------
module i2d_norm import i2d_pkg::*; (
  input  logic                 clk_i,
  input  i2d_stage_en_t        en_i,
  input  logic [MAG_W-1:0]     mag_i,
  output i2d_norm_t            norm_o
);

  logic [MAG_W-1:0] mag_b_q;
  logic [7:0]       nz_b_q, nz_b_d;
  logic [23:0]      loc_b_q, loc_b_d;

  logic [MAG_W-1:0] coarse_c_q, coarse_c_d;
  logic [2:0]       fine_c_q;
  logic [POS_W-1:0] pos_c_q, pos_c_d;
  logic [2:0]       grp_c;
  logic [2:0]       lpos_c;

  logic [MAG_W-1:0] norm_d_q, norm_d_d;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz_b_d[g]           = |mag_i[g*8 +: 8];
      loc_b_d[g*3 +: 3]   = lead8(mag_i[g*8 +: 8]);
    end
  end

  always_comb begin
    grp_c      = lead8(nz_b_q);
    lpos_c     = loc_b_q[grp_c*3 +: 3];
    pos_c_d    = {grp_c, lpos_c};
    coarse_c_d = mag_b_q << {~grp_c, 3'b000};
  end

  assign norm_d_d = coarse_c_q << fine_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      mag_b_q <= mag_i;
      nz_b_q  <= nz_b_d;
      loc_b_q <= loc_b_d;
    end
    if (en_i.en_c) begin
      coarse_c_q <= coarse_c_d;
      fine_c_q   <= ~lpos_c;
      pos_c_q    <= pos_c_d;
    end
    if (en_i.en_d) begin
      norm_d_q <= norm_d_d;
    end
  end

  assign norm_o.pos_c  = pos_c_q;
  assign norm_o.norm_d = norm_d_q;

endmodule

@@ rtl/int_scaled_to_binary64_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_scaled_to_binary64_top: signed integer times a power of two to binary64
// Five stage pipeline: magnitude, byte search, coarse shift, fine shift and
// exponent bias, then special case selection into the output register.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   mantissa_i, exponent_i
// out      output     out_valid_o / out_stall_i double_bits_o, status_o
//
// Each request passes through the five stage registers, one per stage, from acceptance to its result.
// A new request can enter every cycle unless an output stall has filled every stage register.
// Reset empties the pipeline; the payload registers hold no reset value.
// A stall at the output holds the stages behind it; empty stages still fill.
// ----------------------------------------------------------------------------
module int_scaled_to_binary64_top import i2d_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [MAG_W-1:0] mantissa_i,
  input  logic signed [EXP_W-1:0] exponent_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [63:0]             double_bits_o,
  output logic [2:0]              status_o
);

  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic en_a, en_e;
  i2d_stage_en_t en;
  i2d_norm_t     norm;

  logic [MAG_W-1:0] mag_a_q, mag_a_d;
  logic             sign_a_q, sign_b_q, sign_c_q, sign_d_q;
  logic             zero_a_q, zero_b_q, zero_c_q, zero_d_q;
  logic             nan_a_q, nan_b_q, nan_c_q, nan_d_q;
  logic [EXP_W-1:0] ex_a_q, ex_b_q, ex_c_q;
  logic [BIASED_W-1:0] biased_d_q, biased_d_d;

  logic [63:0]  bits_e_q, bits_e_d;
  i2d_status_e  status_e_q, status_e_d;
  logic         ovf_d, unf_d;

  assign rdy_e = ~ve_q | ~out_stall_i;
  assign rdy_d = ~vd_q | rdy_e;
  assign rdy_c = ~vc_q | rdy_d;
  assign rdy_b = ~vb_q | rdy_c;
  assign rdy_a = ~va_q | rdy_b;

  assign en_a    = rdy_a & in_valid_i;
  assign en.en_b = rdy_b & va_q;
  assign en.en_c = rdy_c & vb_q;
  assign en.en_d = rdy_d & vc_q;
  assign en_e    = rdy_e & vd_q;

  assign in_stall_o = ~rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_e) ve_q <= vd_q;
    end
  end

  assign mag_a_d = mantissa_i[MAG_W-1] ? (~mantissa_i + 64'd1) : mantissa_i;

  assign biased_d_d = {ex_c_q[EXP_W-1], ex_c_q}
                    + {{(BIASED_W-POS_W){1'b0}}, norm.pos_c}
                    + BIASED_W'(EXP_BIAS);

  assign ovf_d = $signed(biased_d_q) >= $signed(BIASED_W'(EXP_MAX));
  assign unf_d = biased_d_q[BIASED_W-1] | (biased_d_q == '0);

  always_comb begin
    if (zero_d_q) begin
      bits_e_d   = 64'd0;
      status_e_d = ST_ZERO;
    end else if (nan_d_q) begin
      bits_e_d   = NAN_PATTERN;
      status_e_d = ST_NAN;
    end else if (ovf_d) begin
      bits_e_d   = {sign_d_q, EXPF_W'(EXP_MAX), {FRAC_BITS{1'b0}}};
      status_e_d = ST_OVERFLOW;
    end else if (unf_d) begin
      bits_e_d   = {sign_d_q, 63'd0};
      status_e_d = ST_UNDERFLOW;
    end else begin
      bits_e_d   = {sign_d_q, biased_d_q[EXPF_W-1:0], norm.norm_d[62 -: FRAC_BITS]};
      status_e_d = ST_NORMAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      mag_a_q  <= mag_a_d;
      sign_a_q <= mantissa_i[MAG_W-1];
      zero_a_q <= (mantissa_i == '0);
      nan_a_q  <= (mantissa_i == {1'b1, {(MAG_W-1){1'b0}}});
      ex_a_q   <= exponent_i;
    end
    if (en.en_b) begin
      sign_b_q <= sign_a_q;
      zero_b_q <= zero_a_q;
      nan_b_q  <= nan_a_q;
      ex_b_q   <= ex_a_q;
    end
    if (en.en_c) begin
      sign_c_q <= sign_b_q;
      zero_c_q <= zero_b_q;
      nan_c_q  <= nan_b_q;
      ex_c_q   <= ex_b_q;
    end
    if (en.en_d) begin
      sign_d_q   <= sign_c_q;
      zero_d_q   <= zero_c_q;
      nan_d_q    <= nan_c_q;
      biased_d_q <= biased_d_d;
    end
    if (en_e) begin
      bits_e_q   <= bits_e_d;
      status_e_q <= status_e_d;
    end
  end

  i2d_norm u_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (mag_a_q),
    .norm_o (norm)
  );

  assign out_valid_o   = ve_q;
  assign double_bits_o = bits_e_q;
  assign status_o      = status_e_q;

`ifndef SYNTHESIS
  a_norm_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q && !zero_d_q && !nan_d_q |-> norm.norm_d[MAG_W-1])
    else $error("normalized magnitude lacks its leading one");

  a_nan_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q && nan_d_q && rdy_e |=> out_valid_o && status_o == ST_NAN)
    else $error("most negative mantissa did not give the NaN status");

  a_normal_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NORMAL |->
      double_bits_o[62:52] != '0 && double_bits_o[62:52] != '1)
    else $error("normal result carries a reserved exponent");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q && vb_q && vc_q && vd_q && ve_q && out_stall_i |-> in_stall_o)
    else $error("full pipeline accepted a request during an output stall");
`endif

endmodule

@@ tb/sv/i2d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_checker: result predictor and scoreboard for the binary64 converter
// Watches both channels of the converter. Every accepted request is turned
// into the expected binary64 pattern and status. These are queued in order
// and compared field by field with each accepted result.
// ----------------------------------------------------------------------------
module i2d_checker import i2d_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [MAG_W-1:0] mantissa_i,
  input  logic signed [EXP_W-1:0] exponent_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [63:0]             double_bits_i,
  input  logic [2:0]              status_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [MAG_W-1:0] mantissa;
    logic [EXP_W-1:0] exponent;
    logic [63:0]      bits;
    i2d_status_e      status;
  } conversion_t;

  conversion_t conversions_q[$];
  conversion_t oldest;
  int unsigned fails = 0;

  function automatic conversion_t scaled_to_binary64(input logic [MAG_W-1:0] m,
                                                     input logic [EXP_W-1:0] e);
    conversion_t r;
    logic [63:0] mag;
    logic [63:0] frac;
    int          lead;
    int          biased;
    r.mantissa = m;
    r.exponent = e;
    if (m == '0) begin
      r.bits   = '0;
      r.status = ST_ZERO;
      return r;
    end
    if (m == {1'b1, 63'd0}) begin
      r.bits   = NAN_PATTERN;
      r.status = ST_NAN;
      return r;
    end
    mag  = m[63] ? -m : m;
    lead = 0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) begin
        lead = i;
      end
    end
    biased = int'(signed'(e)) + lead + int'(EXP_BIAS);
    if (biased >= int'(EXP_MAX)) begin
      r.bits   = {m[63], 11'h7FF, 52'd0};
      r.status = ST_OVERFLOW;
    end else if (biased <= 0) begin
      r.bits   = {m[63], 63'd0};
      r.status = ST_UNDERFLOW;
    end else begin
      if (lead >= int'(FRAC_BITS)) begin
        frac = mag >> (lead - int'(FRAC_BITS));
      end else begin
        frac = mag << (int'(FRAC_BITS) - lead);
      end
      r.bits   = {m[63], 11'(biased), frac[51:0]};
      r.status = ST_NORMAL;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conversions_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (conversions_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("%0t: unexpected result bits=%h status=%0d", $realtime,
                     double_bits_i, status_i);
          end
        end else begin
          oldest = conversions_q.pop_front();
          if (double_bits_i !== oldest.bits || status_i !== oldest.status) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("%0t: mantissa=%h exponent=%h: bits %h want %h, status %0d want %0d",
                       $realtime, oldest.mantissa, oldest.exponent, double_bits_i,
                       oldest.bits, status_i, oldest.status);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        conversions_q.push_back(scaled_to_binary64(mantissa_i, exponent_i));
      end
      fail_count_o <= fails;
      pending_o    <= conversions_q.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the scaled integer to binary64 converter
// Sends directed corner requests and then random requests, partly built
// around the infinity and zero thresholds, under random idling on both sides.
// It also applies one long output hold and two full drains. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import i2d_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned TAIL_CYCLES = 20;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic signed [MAG_W-1:0] mantissa_i  = '0;
  logic signed [EXP_W-1:0] exponent_i  = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [63:0]             double_bits_o;
  logic [2:0]              status_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  int unsigned burst_left  = 0;
  bit          src_quiet   = 1'b0;
  bit          sink_quiet  = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_taken  = 1'b0;

  int_scaled_to_binary64_top u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mantissa_i,
    .exponent_i,
    .out_valid_o,
    .out_stall_i,
    .double_bits_o,
    .status_o
  );

  i2d_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .mantissa_i,
    .exponent_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .double_bits_i (double_bits_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (!sink_quiet && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_request(input logic [MAG_W-1:0] m, input logic [EXP_W-1:0] e);
    int unsigned gap;
    if (!src_quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mantissa_i <= m;
    exponent_i <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    int unsigned kind;
    int unsigned width;
    int unsigned band;
    int          target;
    logic [63:0] mag;
    logic [63:0] m;
    logic [15:0] e;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      m = '0;
      e = 16'($urandom);
    end else if (kind < 5) begin
      m = {1'b1, 63'd0};
      e = 16'($urandom);
    end else if (kind < 25) begin
      m = {$urandom, $urandom};
      e = 16'($urandom);
    end else begin
      width = $urandom_range(0, 62);
      mag   = ({$urandom, $urandom} >> (63 - width)) | (64'd1 << width);
      m     = $urandom_range(0, 1) ? -mag : mag;
      band  = $urandom_range(0, 9);
      if (band < 2) begin
        target = int'($urandom_range(0, 4)) - 2;
      end else if (band < 4) begin
        target = 2044 + int'($urandom_range(0, 6));
      end else begin
        target = 1 + int'($urandom_range(0, 2045));
      end
      e = 16'(target - int'(width) - int'(EXP_BIAS));
      if (band == 4) begin
        e = 16'($urandom);
      end
    end
    send_request(m, e);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(64'd0, 16'd0);
    send_request(64'd0, 16'h8000);
    send_request({1'b1, 63'd0}, 16'd0);
    send_request({1'b1, 63'd0}, 16'h7FFF);
    send_request(64'h7FFF_FFFF_FFFF_FFFF, 16'd0);
    send_request(64'h7FFF_FFFF_FFFF_FFFF, 16'h7FFF);
    send_request(64'h8000_0000_0000_0001, 16'h8000);
    send_request(64'd1, 16'(1023));
    send_request(64'd1, 16'(1024));
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 16'(1024));
    send_request(64'd1, 16'(-1022));
    send_request(64'd1, 16'(-1023));
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 16'(-1023));
    send_request(64'h7FFF_FFFF_FFFF_FFFF, 16'(961));
    send_request(64'h7FFF_FFFF_FFFF_FFFF, 16'(962));
    send_request(64'd3, 16'd0);
    send_request(-64'd5, 16'd7);
    send_request(64'h0010_0000_0000_0001, 16'd0);
    send_request(64'h0020_0000_0000_0003, 16'(-3));
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    send_request(64'h8000_0000_0000_0001, 16'd0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 16'(-100));
    send_request(64'h5555_5555_5555_5555, 16'(100));

    repeat (300) send_random_request();

    drain();
    src_quiet = 1'b1;
    hold_req  = 1'b1;
    repeat (40) send_random_request();
    src_quiet = 1'b0;

    repeat (300) send_random_request();

    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    repeat (150) send_random_request();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/i2d_pkg.sv
rtl/i2d_norm.sv
rtl/int_scaled_to_binary64_top.sv
tb/sv/i2d_checker.sv
tb/sv/tb_top.sv
